// File: src/scanline_unpack_nearest_color_defines.svh
// Assertion macros for the scanline unpacker with nearest-color quantizer.
// Included by the top level; expects clk and arst_n in scope.
`ifndef SCANLINE_UNPACK_NEAREST_COLOR_DEFINES_SVH
`define SCANLINE_UNPACK_NEAREST_COLOR_DEFINES_SVH

// Checked only while out of reset.
`define SNU_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define SNU_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/snu_pkg.sv
// Shared types, constants and codes of the scanline unpacker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package snu_pkg;

	localparam int PANEL_WIDTH_DEF   = 1200;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int FIFO_DEPTH        = 4;
	localparam int CFG_W             = 12;

	localparam logic [1:0] REG_BPP     = 2'd0;
	localparam logic [1:0] REG_USE_PAL = 2'd1;
	localparam logic [1:0] REG_WIDTH   = 2'd2;
	localparam logic [1:0] REG_XOFF    = 2'd3;

	localparam logic [5:0] BPP_1  = 6'd1;
	localparam logic [5:0] BPP_2  = 6'd2;
	localparam logic [5:0] BPP_4  = 6'd4;
	localparam logic [5:0] BPP_8  = 6'd8;
	localparam logic [5:0] BPP_16 = 6'd16;
	localparam logic [5:0] BPP_24 = 6'd24;
	localparam logic [5:0] BPP_32 = 6'd32;

	localparam logic [11:0] WIDTH_RESET = 12'd1200;
	localparam logic [7:0]  REF_LEVEL   = 8'd192;

	localparam logic [2:0] CODE_BLACK  = 3'd0;
	localparam logic [2:0] CODE_WHITE  = 3'd1;
	localparam logic [2:0] CODE_GREEN  = 3'd2;
	localparam logic [2:0] CODE_BLUE   = 3'd3;
	localparam logic [2:0] CODE_RED    = 3'd4;
	localparam logic [2:0] CODE_YELLOW = 3'd5;

	// Reference colors in tie-break order.
	localparam int REF_N = 6;
	localparam logic [2:0] REF_CODE [REF_N] = '{
		CODE_BLACK, CODE_WHITE, CODE_YELLOW, CODE_RED, CODE_BLUE, CODE_GREEN
	};

	typedef enum logic [1:0] {
		OP_PAL,
		OP_BYTE,
		OP_RGB
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  index;
		logic [23:0] rgb;
	} work_t;

	typedef struct packed {
		logic [5:0]  bpp;
		logic        use_pal;
		logic [11:0] width;
		logic [10:0] x_off;
	} cfg_t;

	typedef struct packed {
		logic [11:0] column;
		logic        visible;
		logic        row_end;
		logic        last;
	} pix_meta_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_stat_t;

endpackage

// File: src/snu_front.sv
// Front end: accepts input transfers, assembles multi-byte pixels and
// classifies each item into a work entry for the queue. Uses snu_pkg.
`timescale 1ns / 1ps

module snu_front import snu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       bpp_write,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] data_byte,
	input  logic [7:0] entry_index,
	input  logic [7:0] entry_red,
	input  logic [7:0] entry_green,
	input  logic [7:0] entry_blue,
	input  fifo_stat_t fifo_stat,
	output logic       push,
	output work_t      push_data
);

	logic [1:0]  phase_q, phase_d;
	logic [15:0] held_q, held_d;
	logic        accept;
	logic        push_c;
	logic [7:0]  s0;
	logic [23:0] rgb16;

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && push_c;

	assign s0    = held_q[7:0];
	assign rgb16 = {data_byte[7:3], 3'b000,
	                data_byte[2:0], s0[7:5], 2'b00,
	                s0[4:0], 3'b000};

	always_comb begin
		push_c    = 1'b0;
		phase_d   = phase_q;
		held_d    = held_q;
		push_data = '{op: OP_PAL, index: entry_index,
		              rgb: {entry_red, entry_green, entry_blue}};
		if (!kind) begin
			push_c = 1'b1;
		end else begin
			case (cfg.bpp)
				BPP_1, BPP_2, BPP_4, BPP_8: begin
					push_c          = 1'b1;
					push_data.op    = OP_BYTE;
					push_data.index = data_byte;
					phase_d         = 2'd0;
				end
				BPP_16: begin
					if (phase_q == 2'd0) begin
						held_d  = {8'h00, data_byte};
						phase_d = 2'd1;
					end else begin
						push_c        = 1'b1;
						push_data.op  = OP_RGB;
						push_data.rgb = rgb16;
						phase_d       = 2'd0;
					end
				end
				BPP_24, BPP_32: begin
					case (phase_q)
						2'd0: begin
							held_d  = {8'h00, data_byte};
							phase_d = 2'd1;
						end
						2'd1: begin
							held_d  = {held_q[7:0], data_byte};
							phase_d = 2'd2;
						end
						2'd2: begin
							push_c        = 1'b1;
							push_data.op  = OP_RGB;
							push_data.rgb = {held_q, data_byte};
							phase_d       = (cfg.bpp == BPP_32) ? 2'd3 : 2'd0;
						end
						default: begin
							if (cfg.bpp == BPP_24) begin
								push_c        = 1'b1;
								push_data.op  = OP_RGB;
								push_data.rgb = {held_q, data_byte};
							end
							phase_d = 2'd0;
						end
					endcase
				end
				default: begin
					push_c = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			held_q  <= 16'h0000;
		end else if (bpp_write) begin
			phase_q <= 2'd0;
			held_q  <= 16'h0000;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

// File: src/snu_fifo.sv
// Short work queue between the front end and the pixel back end.
// Uses work_t and fifo_stat_t from snu_pkg.
`timescale 1ns / 1ps

module snu_fifo import snu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  work_t      push_data,
	input  logic       pop,
	output work_t      head,
	output fifo_stat_t stat
);

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	work_t         slots_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head           = slots_q[rd_ptr_q];
	assign stat.full      = (count_q == CW'(FIFO_DEPTH));
	assign stat.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/snu_back.sv
// Back end: expands queue entries into pixels, tracks the column and owns
// the palette memory. Uses snu_pkg; feeds the quantizer pipeline.
`timescale 1ns / 1ps

module snu_back import snu_pkg::*; #(
	parameter int PANEL_WIDTH   = PANEL_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        adv,
	input  fifo_stat_t  fifo_stat,
	input  work_t       head,
	output logic        pop,
	output logic        valid_s1,
	output pix_meta_t   meta_s1,
	output logic [23:0] rgb_s1
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [23:0] pal_mem [PALETTE_DEPTH];
	logic [23:0] pal_rd_s1;
	logic [23:0] direct_s1;
	logic        use_pal_s1;
	logic        pal_ok_s1;

	logic [11:0] col_q;
	logic [2:0]  sh;
	logic [7:0]  sb;
	logic [7:0]  pix_idx;
	logic [7:0]  grey;
	logic        last_pos;
	logic        row_end;
	logic [12:0] sum;
	logic        visible;
	logic        done;
	logic        emit;
	logic        pal_we;
	logic        is_byte;

	always_comb begin
		case (cfg.bpp)
			BPP_1:   sh = col_q[2:0];
			BPP_2:   sh = {col_q[1:0], 1'b0};
			BPP_4:   sh = {col_q[0], 2'b00};
			default: sh = 3'd0;
		endcase
	end

	assign sb = head.index << sh;

	always_comb begin
		case (cfg.bpp)
			BPP_1: begin
				pix_idx  = {7'd0, sb[7]};
				grey     = {8{sb[7]}};
				last_pos = (col_q[2:0] == 3'd7);
			end
			BPP_2: begin
				pix_idx  = {6'd0, sb[7:6]};
				grey     = {sb[7:6], 6'd0};
				last_pos = &col_q[1:0];
			end
			BPP_4: begin
				pix_idx  = {4'd0, sb[7:4]};
				grey     = {sb[7:4], sb[7:4]};
				last_pos = col_q[0];
			end
			default: begin
				pix_idx  = head.index;
				grey     = head.index;
				last_pos = 1'b1;
			end
		endcase
	end

	assign is_byte = (head.op == OP_BYTE);
	assign row_end = ({1'b0, col_q} + 13'd1) >= {1'b0, cfg.width};
	assign sum     = {1'b0, col_q} + {2'b00, cfg.x_off};
	assign visible = sum < 13'(PANEL_WIDTH);
	assign done    = !is_byte || row_end || last_pos;
	assign emit    = adv && fifo_stat.not_empty && (head.op != OP_PAL);
	assign pop     = adv && fifo_stat.not_empty && done;
	assign pal_we  = adv && fifo_stat.not_empty && (head.op == OP_PAL)
	                 && ({1'b0, head.index} < 9'(PALETTE_DEPTH));

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[head.index[AW-1:0]] <= head.rgb;
		end
		if (adv) begin
			pal_rd_s1 <= pal_mem[pix_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1    <= '{column: sum[11:0], visible: visible,
			                row_end: row_end, last: done};
			direct_s1  <= is_byte ? {grey, grey, grey} : head.rgb;
			use_pal_s1 <= cfg.use_pal && is_byte;
			pal_ok_s1  <= {1'b0, pix_idx} < 9'(PALETTE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= 12'd0;
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= emit;
			if (emit) begin
				col_q <= row_end ? 12'd0 : col_q + 12'd1;
			end
		end
	end

	assign rgb_s1 = !use_pal_s1 ? direct_s1 : (pal_ok_s1 ? pal_rd_s1 : 24'h000000);

endmodule

// File: src/snu_quant.sv
// Nearest-color quantizer: squares per channel, distance sums, then the
// first-wins minimum over the six reference colors. Uses snu_pkg.
`timescale 1ns / 1ps

module snu_quant import snu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        valid_s1,
	input  pix_meta_t   meta_s1,
	input  logic [23:0] rgb_s1,
	output logic        valid_s4,
	output pix_meta_t   meta_s4,
	output logic [2:0]  code_s4
);

	logic [15:0] sq_lo_s2 [3];
	logic [15:0] sq_hi_s2 [3];
	logic [17:0] dist_s3  [REF_N];
	logic        valid_s2, valid_s3;
	pix_meta_t   meta_s2, meta_s3;

	logic [7:0]  chan [3];
	logic [7:0]  diff [3];
	logic [17:0] best_d;
	logic [2:0]  best_i;

	assign chan[0] = rgb_s1[23:16];
	assign chan[1] = rgb_s1[15:8];
	assign chan[2] = rgb_s1[7:0];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c] = (chan[c] >= REF_LEVEL) ? chan[c] - REF_LEVEL : REF_LEVEL - chan[c];
		end
	end

	always_comb begin
		best_d = dist_s3[0];
		best_i = 3'd0;
		for (int i = 1; i < REF_N; i++) begin
			if (dist_s3[i] < best_d) begin
				best_d = dist_s3[i];
				best_i = 3'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				sq_lo_s2[c] <= 16'(chan[c]) * 16'(chan[c]);
				sq_hi_s2[c] <= 16'(diff[c]) * 16'(diff[c]);
			end
			meta_s2 <= meta_s1;

			dist_s3[0] <= 18'(sq_lo_s2[0]) + 18'(sq_lo_s2[1]) + 18'(sq_lo_s2[2]);
			dist_s3[1] <= 18'(sq_hi_s2[0]) + 18'(sq_hi_s2[1]) + 18'(sq_hi_s2[2]);
			dist_s3[2] <= 18'(sq_hi_s2[0]) + 18'(sq_hi_s2[1]) + 18'(sq_lo_s2[2]);
			dist_s3[3] <= 18'(sq_hi_s2[0]) + 18'(sq_lo_s2[1]) + 18'(sq_lo_s2[2]);
			dist_s3[4] <= 18'(sq_lo_s2[0]) + 18'(sq_lo_s2[1]) + 18'(sq_hi_s2[2]);
			dist_s3[5] <= 18'(sq_lo_s2[0]) + 18'(sq_hi_s2[1]) + 18'(sq_lo_s2[2]);
			meta_s3 <= meta_s2;

			code_s4 <= REF_CODE[best_i];
			meta_s4 <= meta_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

endmodule

// File: src/scanline_unpack_nearest_color.sv
// Top level of the scanline unpacker with nearest six-color quantizer.
// Instantiates snu_front, snu_fifo, snu_back and snu_quant; uses snu_pkg.
//
// Input channel (in_valid/in_ready): one transfer per palette write or
// scanline byte. Output channel (out_valid/out_ready): one transfer per
// source pixel, with last marking the final pixel caused by one input.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, which the block does not enforce. A byte
// of 8, 16, 24 or 32 bit data is taken every cycle while the queue has
// room; a byte of 1, 2 or 4 bit pixels occupies the pixel generator until
// its 8, 4 or 2 pixels are out (fewer at a row end or when the column does
// not start on a byte boundary), and a four-entry work queue absorbs the
// difference before in_ready drops. Only the generator can hold an item
// while the next waits. The queue is written at the transfer edge, then the
// generator with palette read, squares, distance sums and minimum select
// are each registered. Reset clears the configuration to its defaults, the
// column counter, pixel assembly and all valid flags; the palette holds no
// defined contents until written. When out_valid is high and out_ready low
// the back pipeline holds, the queue fills, and then in_ready goes low.
`timescale 1ns / 1ps
`include "scanline_unpack_nearest_color_defines.svh"

module scanline_unpack_nearest_color import snu_pkg::*; #(
	parameter int PANEL_WIDTH   = PANEL_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [7:0]       data_byte,
	input  logic [7:0]       entry_index,
	input  logic [7:0]       entry_red,
	input  logic [7:0]       entry_green,
	input  logic [7:0]       entry_blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       color_code,
	output logic [11:0]      panel_column,
	output logic             visible,
	output logic             row_end,
	output logic             last
);

	cfg_t        cfg_q;
	logic        bpp_write;
	logic        adv;
	logic        push;
	logic        pop;
	work_t       push_data;
	work_t       head;
	fifo_stat_t  fifo_stat;
	logic        valid_s1;
	pix_meta_t   meta_s1;
	logic [23:0] rgb_s1;
	pix_meta_t   meta_s4;
	logic        sub_byte_bpp;

	assign bpp_write = cfg_write && (cfg_index == REG_BPP);
	assign adv       = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bpp: BPP_8, use_pal: 1'b0, width: WIDTH_RESET, x_off: 11'd0};
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BPP:     cfg_q.bpp     <= cfg_data[5:0];
				REG_USE_PAL: cfg_q.use_pal <= cfg_data[0];
				REG_WIDTH:   cfg_q.width   <= cfg_data[11:0];
				REG_XOFF:    cfg_q.x_off   <= cfg_data[10:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	snu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.bpp_write   (bpp_write),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.entry_index (entry_index),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.push_data   (push_data)
	);

	snu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	snu_back #(
		.PANEL_WIDTH   (PANEL_WIDTH),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.adv       (adv),
		.fifo_stat (fifo_stat),
		.head      (head),
		.pop       (pop),
		.valid_s1  (valid_s1),
		.meta_s1   (meta_s1),
		.rgb_s1    (rgb_s1)
	);

	snu_quant u_quant (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.meta_s1  (meta_s1),
		.rgb_s1   (rgb_s1),
		.valid_s4 (out_valid),
		.meta_s4  (meta_s4),
		.code_s4  (color_code)
	);

	assign panel_column = meta_s4.column;
	assign visible      = meta_s4.visible;
	assign row_end      = meta_s4.row_end;
	assign last         = meta_s4.last;

	assign sub_byte_bpp = cfg_q.bpp inside {BPP_1, BPP_2, BPP_4};

	`SNU_ASSERT(a_row_end_is_last, out_valid && row_end |-> last, "row end without last")
	`SNU_ASSERT(a_multi_only_sub_byte, out_valid && !last |-> sub_byte_bpp, "multi-pixel wide byte")
	`SNU_ASSERT(a_code_range, out_valid |-> color_code <= CODE_YELLOW, "color code out of range")
	`SNU_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "output valid after reset")

endmodule
